// ===== hdl/tts_pkg.sv =====
// shared types, character codes and helper functions for the template tag scanner
`default_nettype none
package tts_pkg;

    localparam int ResMax   = 4;
    localparam int CountW   = $clog2(ResMax + 1);
    localparam int IdxW     = $clog2(ResMax);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_TEXT    = 2'd0,
        MODE_CODE    = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    // text match progress codes
    localparam logic [2:0] PROG_NONE     = 3'd0;
    localparam logic [2:0] PROG_LT       = 3'd1;
    localparam logic [2:0] PROG_LT_Q     = 3'd2;
    localparam logic [2:0] PROG_LT_BANG  = 3'd3;
    localparam logic [2:0] PROG_LT_BANG_DASH = 3'd4;

    localparam logic [2:0] SEC_TEXT = 3'd0;

    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_Q     = 8'h3f;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_C     = 8'h63;

    typedef struct packed {
        mode_t      mode;
        logic [2:0] prog;
        logic [2:0] sect;
    } scan_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [2:0] sect;
    } result_t;

    typedef result_t [ResMax-1:0] result_vec_t;

    function automatic logic [2:0] opener_kind(input logic [7:0] b);
        logic [2:0] k;
        case (b)
            CH_H:    k = 3'd1;
            CH_T:    k = 3'd2;
            CH_M:    k = 3'd3;
            CH_I:    k = 3'd4;
            CH_R:    k = 3'd5;
            CH_EQ:   k = 3'd6;
            CH_C:    k = 3'd7;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] held_count(input logic [2:0] p);
        logic [1:0] c;
        case (p)
            PROG_LT:           c = 2'd1;
            PROG_LT_Q:         c = 2'd2;
            PROG_LT_BANG:      c = 2'd2;
            PROG_LT_BANG_DASH: c = 2'd3;
            default:           c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] held_byte(input logic [2:0] p, input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = CH_LT;
            2'd1:    c = (p == PROG_LT_Q) ? CH_Q : CH_BANG;
            default: c = CH_DASH;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tts_step.sv =====
// next-state and result list for one scanned byte or end marker
`default_nettype none
module tts_step
    import tts_pkg::*;
(
    input  wire scan_state_t cur,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    output scan_state_t      nxt,
    output result_vec_t      res,
    output logic [CountW-1:0] res_count
);

    logic [CountW-1:0] n;
    logic [1:0]        hc;
    logic [2:0]        ok;
    logic              text_hold;

    always_comb
    begin
        nxt       = cur;
        res       = '0;
        n         = '0;
        hc        = held_count(cur.prog);
        ok        = opener_kind(in_byte);
        text_hold = 1'b0;

        if (end_of_input)
        begin
            if (cur.mode == MODE_CODE)
            begin
                if (cur.prog != PROG_NONE)
                begin
                    res[0] = '{kind: KIND_BYTE, data: CH_Q, sect: cur.sect};
                    n = CountW'(1);
                end
                res[n[IdxW-1:0]] = '{kind: KIND_CLOSE, data: 8'd0, sect: cur.sect};
                n = n + CountW'(1);
            end
            else if (cur.mode != MODE_COMMENT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (i < int'(hc))
                        res[i] = '{kind: KIND_BYTE, data: held_byte(cur.prog, 2'(i)),
                                   sect: SEC_TEXT};
                end
                n = CountW'(hc);
            end
            res[n[IdxW-1:0]] = '{kind: KIND_END, data: 8'd0, sect: SEC_TEXT};
            n = n + CountW'(1);
            nxt = '{mode: MODE_TEXT, prog: PROG_NONE, sect: SEC_TEXT};
        end
        else if (cur.mode == MODE_CODE)
        begin
            if (cur.prog != PROG_NONE && in_byte == CH_GT)
            begin
                res[0] = '{kind: KIND_CLOSE, data: 8'd0, sect: cur.sect};
                n = CountW'(1);
                nxt = '{mode: MODE_TEXT, prog: PROG_NONE, sect: SEC_TEXT};
            end
            else
            begin
                if (cur.prog != PROG_NONE)
                begin
                    res[0] = '{kind: KIND_BYTE, data: CH_Q, sect: cur.sect};
                    n = CountW'(1);
                end
                if (in_byte == CH_Q)
                    nxt.prog = PROG_LT;
                else
                begin
                    nxt.prog = PROG_NONE;
                    res[n[IdxW-1:0]] = '{kind: KIND_BYTE, data: in_byte, sect: cur.sect};
                    n = n + CountW'(1);
                end
            end
        end
        else if (cur.mode == MODE_COMMENT)
        begin
            if (in_byte == CH_GT && cur.prog >= 3'd2)
                nxt = '{mode: MODE_TEXT, prog: PROG_NONE, sect: cur.sect};
            else if (in_byte == CH_DASH)
                nxt.prog = (cur.prog < 3'd2) ? cur.prog + 3'd1 : 3'd2;
            else
                nxt.prog = PROG_NONE;
        end
        else
        begin
            // plain text, spare mode code behaves the same
            case (cur.prog)
                PROG_LT:
                begin
                    if (in_byte == CH_Q)
                    begin
                        nxt.prog = PROG_LT_Q;
                        text_hold = 1'b1;
                    end
                    else if (in_byte == CH_BANG)
                    begin
                        nxt.prog = PROG_LT_BANG;
                        text_hold = 1'b1;
                    end
                end
                PROG_LT_Q:
                begin
                    if (ok != 3'd0)
                    begin
                        nxt = '{mode: MODE_CODE, prog: PROG_NONE, sect: ok};
                        res[0] = '{kind: KIND_OPEN, data: 8'd0, sect: ok};
                        n = CountW'(1);
                        text_hold = 1'b1;
                    end
                end
                PROG_LT_BANG:
                begin
                    if (in_byte == CH_DASH)
                    begin
                        nxt.prog = PROG_LT_BANG_DASH;
                        text_hold = 1'b1;
                    end
                end
                PROG_LT_BANG_DASH:
                begin
                    if (in_byte == CH_DASH)
                    begin
                        nxt.mode = MODE_COMMENT;
                        nxt.prog = PROG_NONE;
                        text_hold = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (!text_hold)
            begin
                // failed match: flush held bytes, then rescan this byte from idle
                for (int i = 0; i < 3; i++)
                begin
                    if (i < int'(hc))
                        res[i] = '{kind: KIND_BYTE, data: held_byte(cur.prog, 2'(i)),
                                   sect: SEC_TEXT};
                end
                n = CountW'(hc);
                if (in_byte == CH_LT)
                    nxt.prog = PROG_LT;
                else
                begin
                    nxt.prog = PROG_NONE;
                    res[n[IdxW-1:0]] = '{kind: KIND_BYTE, data: in_byte, sect: SEC_TEXT};
                    n = n + CountW'(1);
                end
            end
        end

        res_count = n;
    end

endmodule
`default_nettype wire

// ===== hdl/template_tag_scanner_top.sv =====
// template tag scanner top level: scan state, result buffer and handshakes
//
// usage
//   input channel: in_byte / end_of_input with in_valid / in_ready. one
//   transaction is one template byte, or the end marker that flushes any
//   held bytes, closes an open section and reports end of stream.
//   output channel: kind / out_byte / section / last_of_run with out_valid /
//   out_ready. each input transaction yields zero to four output
//   transactions; last_of_run marks the final one of the group.
// buffering and throughput
//   results are registered and appear in the cycle after the input is taken.
//   the result buffer holds the group of one input and drains one result per
//   cycle while out_ready is high, and an input giving none leaves the input
//   side free in the next cycle. a new input is taken in the same cycle the
//   last buffered result leaves, so a plain byte stream runs at one byte per
//   cycle while out_ready is high.
// reset and stall
//   reset empties the buffer and returns the scanner to plain text with
//   nothing held. while out_ready is low the buffered result holds steady
//   and in_ready stays low until the final buffered result leaves.
`default_nettype none
module template_tag_scanner_top
    import tts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic [2:0]      section,
    output logic            last_of_run
);

    scan_state_t       state_reg;
    scan_state_t       state_next;
    result_vec_t       buf_reg;
    result_vec_t       step_res;
    logic [CountW-1:0] step_count;
    logic [CountW-1:0] cnt_reg;
    logic [IdxW-1:0]   rd_reg;
    logic              is_last;
    logic              in_fire;
    logic              out_fire;
    result_t           head;

    tts_step u_step (
        .cur          (state_reg),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .nxt          (state_next),
        .res          (step_res),
        .res_count    (step_count)
    );

    assign head        = buf_reg[rd_reg];
    assign out_valid   = (cnt_reg != '0);
    assign is_last     = ({1'b0, rd_reg} == cnt_reg - CountW'(1));
    assign in_ready    = (cnt_reg == '0) || (is_last && out_ready);
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;
    assign kind        = head.kind;
    assign out_byte    = head.data;
    assign section     = head.sect;
    assign last_of_run = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_TEXT, prog: PROG_NONE, sect: SEC_TEXT};
            cnt_reg   <= '0;
            rd_reg    <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            cnt_reg   <= step_count;
            rd_reg    <= '0;
        end
        else if (out_fire)
        begin
            if (is_last)
                cnt_reg <= '0;
            else
                rd_reg <= rd_reg + IdxW'(1);
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            buf_reg <= step_res;
    end

endmodule
`default_nettype wire
